>>> design/assert_macros.svh
// Assertion macros used by the calendar conversion design files.
// No dependencies; included by every file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/ntl_pkg.sv
// Types, constants and small functions shared by the calendar conversion design.
// No dependencies.
`default_nettype none

package ntl_pkg;

   localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
   localparam logic [15:0] SECS_PER_HOUR  = 16'd3600;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [3:0]  TZ_RESET       = 4'd1;

   // Reciprocals for division by constants. Each is exact over the value range it is used on.
   localparam logic [28:0] MS_RECIP    = 29'd274877907; // (x * r) >> 38 is x / 1000
   localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // ((t >> 7) * r) >> 35 is t / 86400
   localparam logic [15:0] Y1460_RECIP = 16'd45965;     // ((d >> 2) * r) >> 24 is d / 1460
   localparam logic [17:0] Y365_RECIP  = 18'd183860;    // (d * r) >> 26 is d / 365
   localparam logic [12:0] HOUR_RECIP  = 13'd4661;      // ((s >> 4) * r) >> 20 is s / 3600
   localparam logic [10:0] MIN_RECIP   = 11'd1093;      // ((s >> 2) * r) >> 14 is s / 60
   localparam logic [16:0] WDAY_RECIP  = 17'd74899;     // (d * r) >> 19 is d / 7
   localparam logic [12:0] MOD7_RECIP  = 13'd4682;      // (x * r) >> 15 is x / 7

   // Day-count constants of the 400-year Gregorian era, counted from 0000-03-01.
   localparam logic [19:0] EPOCH_DAYS = 20'd719468;
   localparam logic [19:0] ERA4_START = 20'd584388;
   localparam logic [19:0] ERA5_START = 20'd730485;
   localparam logic [17:0] CENT_DAYS  = 18'd36524;

   localparam logic [3:0] MONTH_MARCH     = 4'd3;
   localparam logic [3:0] MONTH_APRIL     = 4'd4;
   localparam logic [3:0] MONTH_SEPTEMBER = 4'd9;
   localparam logic [3:0] MONTH_OCTOBER   = 4'd10;

   localparam int SPLIT_STAGES = 7;
   localparam int DST_STAGES   = 4;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_type;

   typedef struct packed {
      logic [31:0] t;
      logic        summer;
   } side_type;

   // First day of each month in a year that starts on 1 March.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] ofs;
      case (mp)
         4'd0:    ofs = 9'd0;
         4'd1:    ofs = 9'd31;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd92;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd153;
         4'd6:    ofs = 9'd184;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd245;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd306;
         4'd11:   ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

   // Month index from March, found by comparing against every month start in parallel.
   function automatic logic [3:0] month_index(input logic [8:0] doy);
      logic [3:0] idx;
      idx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy >= month_start(4'(k))) begin
            idx = idx + 4'd1;
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> design/ntl_front.sv
// Front stages: NTP seconds to local standard-time seconds, two register stages.
// Depends on ntl_pkg.
`default_nettype none

module ntl_front
   import ntl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [3:0]  tz_hours,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [31:0] ntp_seconds,
   input  wire logic [31:0] elapsed_ms,
   output logic             out_valid,
   input  wire logic        out_ready,
   output side_type         out_side
);

   logic [1:0]  v_ff, v_in, adv;
   logic [15:0] tz_secs;
   logic [31:0] base_ff, base_in;
   logic [60:0] ms_prod_ff, ms_prod_in;
   logic [31:0] t_ff, t_in;

   assign adv[1]   = !v_ff[1] || out_ready;
   assign adv[0]   = !v_ff[0] || adv[1];
   assign v_in     = (v_ff & ~adv) | ({v_ff[0], in_valid} & adv);
   assign in_ready = adv[0];

   // All sums wrap modulo 2^32, which also maps stamps before 1970 into the next NTP era.
   assign tz_secs    = 16'(tz_hours) * SECS_PER_HOUR;
   assign base_in    = ntp_seconds + {16'd0, tz_secs} - NTP_UNIX_DELTA;
   assign ms_prod_in = 61'(elapsed_ms) * 61'(MS_RECIP);
   assign t_in       = base_ff + {9'd0, ms_prod_ff[60:38]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         base_ff    <= base_in;
         ms_prod_ff <= ms_prod_in;
      end
      if (adv[1]) begin
         t_ff <= t_in;
      end
   end

   always_comb begin
      out_side.t      = t_ff;
      out_side.summer = 1'b0;
   end

   assign out_valid = v_ff[1];

endmodule

`default_nettype wire

>>> design/ntl_split.sv
// Seven-stage pipeline that splits Unix seconds into Gregorian calendar fields.
// Depends on ntl_pkg and assert_macros.svh; the side payload passes through untouched.
`default_nettype none
`include "assert_macros.svh"

module ntl_split
   import ntl_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire side_type in_side,
   output logic          out_valid,
   input  wire logic     out_ready,
   output cal_type       out_cal,
   output side_type      out_side
);

   logic [SPLIT_STAGES-1:0] v_ff, v_in, adv;

   // Stage 1
   logic [31:0] p1_t_ff;
   side_type    p1_side_ff;
   logic [50:0] p1_prod_ff, p1_prod_in;
   // Stage 2
   logic [15:0] days;
   logic [31:0] day_secs, sod_full;
   logic [19:0] z, doe_full;
   logic        era5;
   logic [15:0] p2_days_ff;
   logic [16:0] p2_sod_ff;
   logic [17:0] p2_doe_ff;
   logic        p2_era5_ff;
   side_type    p2_side_ff;
   // Stage 3
   logic [16:0] wx;
   logic [17:0] p3_doe_ff;
   logic        p3_era5_ff;
   logic [16:0] p3_sod_ff, p3_wx_ff;
   logic [31:0] p3_q1460_ff, p3_q1460_in;
   logic [2:0]  p3_cent_ff, p3_cent_in;
   logic [25:0] p3_hprod_ff, p3_hprod_in;
   logic [33:0] p3_wprod_ff, p3_wprod_in;
   side_type    p3_side_ff;
   // Stage 4
   logic [17:0] yq;
   logic [4:0]  hour;
   logic [16:0] rem_full, wd_full;
   logic [12:0] wq;
   logic [17:0] p4_doe_ff, p4_yq_ff;
   logic        p4_era5_ff;
   logic [4:0]  p4_hour_ff;
   logic [11:0] p4_rem_ff;
   logic [2:0]  p4_wday_ff;
   side_type    p4_side_ff;
   // Stage 5
   logic [17:0] p5_doe_ff;
   logic        p5_era5_ff;
   logic [4:0]  p5_hour_ff;
   logic [2:0]  p5_wday_ff;
   logic [11:0] p5_rem_ff;
   logic [35:0] p5_yprod_ff, p5_yprod_in;
   logic [20:0] p5_mprod_ff, p5_mprod_in;
   side_type    p5_side_ff;
   // Stage 6
   logic [8:0]  yoe;
   logic [1:0]  yoe_cent;
   logic [17:0] yday, doy_full;
   logic [5:0]  minute;
   logic [11:0] sec_full;
   logic        p6_era5_ff;
   logic [8:0]  p6_yoe_ff, p6_doy_ff;
   logic [4:0]  p6_hour_ff;
   logic [2:0]  p6_wday_ff;
   logic [5:0]  p6_min_ff, p6_sec_ff;
   side_type    p6_side_ff;
   // Stage 7
   logic [3:0]  mp;
   logic        late;
   logic [8:0]  day_full;
   cal_type     cal_ff, cal_in;
   side_type    side_ff;

   assign adv[6]   = !v_ff[6] || out_ready;
   assign adv[5]   = !v_ff[5] || adv[6];
   assign adv[4]   = !v_ff[4] || adv[5];
   assign adv[3]   = !v_ff[3] || adv[4];
   assign adv[2]   = !v_ff[2] || adv[3];
   assign adv[1]   = !v_ff[1] || adv[2];
   assign adv[0]   = !v_ff[0] || adv[1];
   assign v_in     = (v_ff & ~adv) | ({v_ff[SPLIT_STAGES-2:0], in_valid} & adv);
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: reciprocal product for the day count.
   assign p1_prod_in = 51'(in_side.t[31:7]) * 51'(DAY_RECIP);

   // Stage 2: day count, seconds of the day, and day within the 400-year era.
   assign days     = p1_prod_ff[50:35];
   assign day_secs = 32'(days) * 32'(SECS_PER_DAY);
   assign sod_full = p1_t_ff - day_secs;
   assign z        = 20'(days) + EPOCH_DAYS;
   assign era5     = z >= ERA5_START;
   assign doe_full = z - (era5 ? ERA5_START : ERA4_START);

   // Stage 3: products for years, hours and weekday; century corrections by compare.
   assign wx          = 17'(p2_days_ff) + 17'd3;
   assign p3_q1460_in = 32'(p2_doe_ff[17:2]) * 32'(Y1460_RECIP);
   assign p3_cent_in  = 3'(p2_doe_ff >= CENT_DAYS) + 3'(p2_doe_ff >= 18'(CENT_DAYS * 2))
                      + 3'(p2_doe_ff >= 18'(CENT_DAYS * 3));
   assign p3_hprod_in = 26'(p2_sod_ff[16:4]) * 26'(HOUR_RECIP);
   assign p3_wprod_in = 34'(wx) * 34'(WDAY_RECIP);

   // Stage 4: leap-corrected day count, hour with its remainder, weekday.
   // On the last day of the era the fourth century step and the era-end term cancel,
   // so the three compares in p3_cent_ff give the whole correction.
   assign yq       = p3_doe_ff - 18'(p3_q1460_ff[31:24]) + 18'(p3_cent_ff);
   assign hour     = p3_hprod_ff[24:20];
   assign rem_full = p3_sod_ff - 17'(hour) * 17'(SECS_PER_HOUR);
   assign wq       = p3_wprod_ff[31:19];
   assign wd_full  = p3_wx_ff - 17'(wq) * 17'd7;

   // Stage 5: products for year of era and minute.
   assign p5_yprod_in = 36'(p4_yq_ff) * 36'(Y365_RECIP);
   assign p5_mprod_in = 21'(p4_rem_ff[11:2]) * 21'(MIN_RECIP);

   // Stage 6: day of year, minute and second.
   assign yoe      = p5_yprod_ff[34:26];
   assign yoe_cent = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
   assign yday     = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_cent);
   assign doy_full = p5_doe_ff - yday;
   assign minute   = p5_mprod_ff[19:14];
   assign sec_full = p5_rem_ff - 12'(minute) * 12'd60;

   // Stage 7: month, day and year. The year runs from March, so January and February
   // belong to the following calendar year.
   assign mp       = month_index(p6_doy_ff);
   assign late     = mp >= 4'd10;
   assign day_full = p6_doy_ff - month_start(mp) + 9'd1;

   always_comb begin
      cal_in.year    = 12'(p6_yoe_ff) + (p6_era5_ff ? 12'd2000 : 12'd1600) + 12'(late);
      cal_in.month   = late ? mp - 4'd9 : mp + 4'd3;
      cal_in.day     = day_full[4:0];
      cal_in.weekday = p6_wday_ff;
      cal_in.hour    = p6_hour_ff;
      cal_in.minute  = p6_min_ff;
      cal_in.second  = p6_sec_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p1_t_ff    <= in_side.t;
         p1_side_ff <= in_side;
         p1_prod_ff <= p1_prod_in;
      end
      if (adv[1]) begin
         p2_days_ff <= days;
         p2_sod_ff  <= sod_full[16:0];
         p2_doe_ff  <= doe_full[17:0];
         p2_era5_ff <= era5;
         p2_side_ff <= p1_side_ff;
      end
      if (adv[2]) begin
         p3_doe_ff   <= p2_doe_ff;
         p3_era5_ff  <= p2_era5_ff;
         p3_sod_ff   <= p2_sod_ff;
         p3_wx_ff    <= wx;
         p3_q1460_ff <= p3_q1460_in;
         p3_cent_ff  <= p3_cent_in;
         p3_hprod_ff <= p3_hprod_in;
         p3_wprod_ff <= p3_wprod_in;
         p3_side_ff  <= p2_side_ff;
      end
      if (adv[3]) begin
         p4_doe_ff  <= p3_doe_ff;
         p4_era5_ff <= p3_era5_ff;
         p4_yq_ff   <= yq;
         p4_hour_ff <= hour;
         p4_rem_ff  <= rem_full[11:0];
         p4_wday_ff <= wd_full[2:0];
         p4_side_ff <= p3_side_ff;
      end
      if (adv[4]) begin
         p5_doe_ff   <= p4_doe_ff;
         p5_era5_ff  <= p4_era5_ff;
         p5_hour_ff  <= p4_hour_ff;
         p5_wday_ff  <= p4_wday_ff;
         p5_rem_ff   <= p4_rem_ff;
         p5_yprod_ff <= p5_yprod_in;
         p5_mprod_ff <= p5_mprod_in;
         p5_side_ff  <= p4_side_ff;
      end
      if (adv[5]) begin
         p6_era5_ff <= p5_era5_ff;
         p6_yoe_ff  <= yoe;
         p6_doy_ff  <= doy_full[8:0];
         p6_hour_ff <= p5_hour_ff;
         p6_wday_ff <= p5_wday_ff;
         p6_min_ff  <= minute;
         p6_sec_ff  <= sec_full[5:0];
         p6_side_ff <= p5_side_ff;
      end
      if (adv[6]) begin
         cal_ff  <= cal_in;
         side_ff <= p6_side_ff;
      end
   end

   assign out_valid = v_ff[SPLIT_STAGES-1];
   assign out_cal   = cal_ff;
   assign out_side  = side_ff;

   `ASSERT_IMPLIES(a_month, clock, reset, out_valid, cal_ff.month >= 4'd1 && cal_ff.month <= 4'd12)
   `ASSERT_IMPLIES(a_day, clock, reset, out_valid, cal_ff.day != 5'd0)
   `ASSERT_IMPLIES(a_hour, clock, reset, out_valid, cal_ff.hour <= 5'd23)
   `ASSERT_IMPLIES(a_min_sec, clock, reset, out_valid, cal_ff.minute <= 6'd59 && cal_ff.second <= 6'd59)
   `ASSERT_IMPLIES(a_wday_range, clock, reset, out_valid, cal_ff.weekday <= 3'd6)

endmodule

`default_nettype wire

>>> design/ntl_dst.sv
// Four-stage pipeline for the EU summer-time rule on standard-time calendar fields.
// Depends on ntl_pkg; adds the summer hour to the seconds count when the rule applies.
`default_nettype none

module ntl_dst
   import ntl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] tz_hours,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cal_type    in_cal,
   input  wire side_type   in_side,
   output logic            out_valid,
   input  wire logic       out_ready,
   output side_type        out_side
);

   logic [DST_STAGES-1:0] v_ff, v_in, adv;

   logic [14:0] year5;
   logic [9:0]  now_in;
   logic [31:0] e1_t_ff;
   logic [3:0]  e1_month_ff;
   logic [9:0]  e1_now_ff;
   logic [12:0] e1_k_ff;

   logic [12:0] x4, x1;
   logic [31:0] e2_t_ff;
   logic [3:0]  e2_month_ff;
   logic [9:0]  e2_now_ff;
   logic [12:0] e2_x4_ff, e2_x1_ff;
   logic [25:0] e2_p4_ff, e2_p1_ff;

   logic [12:0] r4_full, r1_full;
   logic [9:0]  lim_mar, lim_oct;
   logic        summer;
   logic [31:0] e3_t_ff;
   logic        e3_summer_ff;

   side_type    e4_side_ff, e4_side_in;

   assign adv[3]   = !v_ff[3] || out_ready;
   assign adv[2]   = !v_ff[2] || adv[3];
   assign adv[1]   = !v_ff[1] || adv[2];
   assign adv[0]   = !v_ff[0] || adv[1];
   assign v_in     = (v_ff & ~adv) | ({v_ff[DST_STAGES-2:0], in_valid} & adv);
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: hour count as day times 24 plus hour, and the year term of the Sunday formula.
   assign year5  = 15'(in_cal.year) * 15'd5;
   assign now_in = 10'(in_cal.hour) + 10'(in_cal.day) * 10'd24;

   // Stage 2: reciprocal products for the two modulo-seven residues.
   assign x4 = e1_k_ff + 13'd4;
   assign x1 = e1_k_ff + 13'd1;

   // Stage 3: the change falls on the last Sunday at 01:00 UTC, expressed in local
   // standard hours as day times 24 plus hour.
   assign r4_full = e2_x4_ff - 13'(e2_p4_ff[25:15]) * 13'd7;
   assign r1_full = e2_x1_ff - 13'(e2_p1_ff[25:15]) * 13'd7;
   assign lim_mar = 10'd1 + 10'(tz_hours) + 10'(5'd31 - 5'(r4_full[2:0])) * 10'd24;
   assign lim_oct = 10'd1 + 10'(tz_hours) + 10'(5'd31 - 5'(r1_full[2:0])) * 10'd24;

   always_comb begin
      unique case (e2_month_ff) inside
         MONTH_MARCH:                     summer = e2_now_ff >= lim_mar;
         MONTH_OCTOBER:                   summer = e2_now_ff < lim_oct;
         [MONTH_APRIL:MONTH_SEPTEMBER]:   summer = 1'b1;
         default:                         summer = 1'b0;
      endcase
   end

   // Stage 4: add the summer hour, wrapping modulo 2^32.
   always_comb begin
      e4_side_in.t      = e3_t_ff + (e3_summer_ff ? 32'(SECS_PER_HOUR) : 32'd0);
      e4_side_in.summer = e3_summer_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         e1_t_ff     <= in_side.t;
         e1_month_ff <= in_cal.month;
         e1_now_ff   <= now_in;
         e1_k_ff     <= year5[14:2];
      end
      if (adv[1]) begin
         e2_t_ff     <= e1_t_ff;
         e2_month_ff <= e1_month_ff;
         e2_now_ff   <= e1_now_ff;
         e2_x4_ff    <= x4;
         e2_x1_ff    <= x1;
         e2_p4_ff    <= 26'(x4) * 26'(MOD7_RECIP);
         e2_p1_ff    <= 26'(x1) * 26'(MOD7_RECIP);
      end
      if (adv[2]) begin
         e3_t_ff      <= e2_t_ff;
         e3_summer_ff <= summer;
      end
      if (adv[3]) begin
         e4_side_ff <= e4_side_in;
      end
   end

   assign out_valid = v_ff[DST_STAGES-1];
   assign out_side  = e4_side_ff;

endmodule

`default_nettype wire

>>> design/ntp_time_to_local_calendar.sv
// Top level: NTP timestamp to local calendar time with the EU summer-time rule.
// Depends on ntl_pkg, ntl_front, ntl_split, ntl_dst and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one timestamp item per clock while the result side keeps taking items and returns
// one calendar item per item, in order. Every stage is a single register with its own
// valid bit and ready is passed back stage by stage, so a stall on the result side only
// fills empty stages and the input keeps moving until the pipeline is full. The pipeline
// is made of two seven-stage calendar splits (standard time, then local time after the
// summer hour), two front stages that form Unix seconds and add the offset and elapsed
// whole seconds, and four stages for the summer-time rule. The offset register tz_hours
// resets to 1 and is written with csr_wr_en; write it only while no item is in flight.
// The EU rule formula is exact for 1900 to 2099.
module ntp_time_to_local_calendar
   import ntl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,  // tz_hours
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,    // [31:0] ntp_seconds, [63:32] elapsed_ms
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day, [23:21] weekday, [28:24] hour,
   // [34:29] minute, [40:35] second, [41] summer, [47:42] zero
   output logic [47:0]      rsp_tdata
);

   logic [3:0] tz_ff;

   logic       fr_valid, fr_ready;
   side_type   fr_side;
   logic       std_valid, std_ready;
   cal_type    std_cal;
   side_type   std_side;
   logic       dst_valid, dst_ready;
   side_type   dst_side;
   cal_type    loc_cal;
   side_type   loc_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= TZ_RESET;
      end else if (csr_wr_en) begin
         tz_ff <= csr_wr_data;
      end
   end

   ntl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .tz_hours    (tz_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .ntp_seconds (req_tdata[31:0]),
      .elapsed_ms  (req_tdata[63:32]),
      .out_valid   (fr_valid),
      .out_ready   (fr_ready),
      .out_side    (fr_side)
   );

   ntl_split u_split_std (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_side   (fr_side),
      .out_valid (std_valid),
      .out_ready (std_ready),
      .out_cal   (std_cal),
      .out_side  (std_side)
   );

   ntl_dst u_dst (
      .clock     (clock),
      .reset     (reset),
      .tz_hours  (tz_ff),
      .in_valid  (std_valid),
      .in_ready  (std_ready),
      .in_cal    (std_cal),
      .in_side   (std_side),
      .out_valid (dst_valid),
      .out_ready (dst_ready),
      .out_side  (dst_side)
   );

   ntl_split u_split_loc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dst_valid),
      .in_ready  (dst_ready),
      .in_side   (dst_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cal   (loc_cal),
      .out_side  (loc_side)
   );

   assign rsp_tdata = {6'd0, loc_side.summer, loc_cal.second, loc_cal.minute, loc_cal.hour,
                       loc_cal.weekday, loc_cal.day, loc_cal.month, loc_cal.year};

   // Summer time can only be flagged between March and October, and the added hour never
   // carries October into November.
   `ASSERT_IMPLIES(a_summer_months, clock, reset, rsp_tvalid && loc_side.summer, loc_cal.month >= MONTH_MARCH && loc_cal.month <= MONTH_OCTOBER)
   `ASSERT_NEXT(a_csr_write, clock, reset, csr_wr_en, tz_ff == $past(csr_wr_data))

endmodule

`default_nettype wire

>>> dv/tb_ntp_time_to_local_calendar.sv
// Self-checking testbench for ntp_time_to_local_calendar: NTP timestamps in, local calendar out.
// Needs ntl_pkg and the design; a scoreboard class predicts every calendar item and checks it.
`timescale 1ns / 100ps

module tb_ntp_time_to_local_calendar;
   import ntl_pkg::*;

   localparam int RANDOM_PER_PHASE = 250;
   localparam int NUM_PHASES       = 6;

   // Calendar item as it sits on rsp_tdata, lowest field last.
   typedef struct packed {
      logic [5:0]  pad;
      logic        summer;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } local_time_type;

   typedef struct {
      int unsigned year, month, day, weekday, hour, minute, second;
   } civil_fields_type;

   class calendar_scoreboard;
      logic [3:0]     tz_hours;
      local_time_type pending_times[$];
      int unsigned    errors;
      int unsigned    checked;
      int unsigned    summer_seen;

      function new();
         tz_hours    = TZ_RESET;
         errors      = 0;
         checked     = 0;
         summer_seen = 0;
      endfunction

      function void set_offset(logic [3:0] v);
         tz_hours = v;
      endfunction

      function int pending();
         return pending_times.size();
      endfunction

      // Seconds since 1970 to proleptic Gregorian fields, via days counted from 0000-03-01.
      function civil_fields_type split_seconds(int unsigned t);
         civil_fields_type c;
         int unsigned days, sod, z, era, doe, yoe, doy, mp, mon;
         days = t / 86400;
         sod  = t % 86400;
         z    = days + 719468;
         era  = z / 146097;
         doe  = z - era * 146097;
         yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp   = (5 * doy + 2) / 153;
         mon  = (mp < 10) ? mp + 3 : mp - 9;
         c.year    = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
         c.month   = mon;
         c.day     = doy - (153 * mp + 2) / 5 + 1;
         c.weekday = (days + 3) % 7;
         c.hour    = sod / 3600;
         c.minute  = (sod % 3600) / 60;
         c.second  = sod % 60;
         return c;
      endfunction

      // EU rule judged on standard-time fields; the switch falls at 01:00 UTC, i.e. 1 + tz local.
      function bit summer_in_force(civil_fields_type s, int unsigned tz);
         int unsigned now;
         now = s.hour + 24 * s.day;
         if (s.month < MONTH_MARCH || s.month > MONTH_OCTOBER) return 1'b0;
         if (s.month > MONTH_MARCH && s.month < MONTH_OCTOBER) return 1'b1;
         if (s.month == MONTH_MARCH)
            return now >= 1 + tz + 24 * (31 - (5 * s.year / 4 + 4) % 7);
         return now < 1 + tz + 24 * (31 - (5 * s.year / 4 + 1) % 7);
      endfunction

      function local_time_type local_time(logic [31:0] ntp, logic [31:0] ms);
         int unsigned      t;
         civil_fields_type std_f, loc_f;
         bit               in_summer;
         local_time_type   r;
         t = ntp - NTP_UNIX_DELTA;
         t = t + ms / 1000;
         t = t + tz_hours * 3600;
         std_f = split_seconds(t);
         in_summer = summer_in_force(std_f, tz_hours);
         if (in_summer) t = t + 3600;
         loc_f = split_seconds(t);
         r.pad     = '0;
         r.summer  = in_summer;
         r.second  = loc_f.second[5:0];
         r.minute  = loc_f.minute[5:0];
         r.hour    = loc_f.hour[4:0];
         r.weekday = loc_f.weekday[2:0];
         r.day     = loc_f.day[4:0];
         r.month   = loc_f.month[3:0];
         r.year    = loc_f.year[11:0];
         return r;
      endfunction

      function void note_item(logic [63:0] d);
         local_time_type r;
         r = local_time(d[31:0], d[63:32]);
         if (r.summer) summer_seen++;
         pending_times.push_back(r);
      endfunction

      function void compare_field(string name, logic [11:0] want, logic [11:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [47:0] d);
         local_time_type want, got;
         if (pending_times.size() == 0) begin
            $display("%0t: calendar item %h arrived with none outstanding", $time, d);
            errors++;
            return;
         end
         want = pending_times.pop_front();
         got  = d;
         checked++;
         compare_field("year",    want.year,    got.year);
         compare_field("month",   want.month,   got.month);
         compare_field("day",     want.day,     got.day);
         compare_field("weekday", want.weekday, got.weekday);
         compare_field("hour",    want.hour,    got.hour);
         compare_field("minute",  want.minute,  got.minute);
         compare_field("second",  want.second,  got.second);
         compare_field("summer",  want.summer,  got.summer);
         compare_field("padding", want.pad,     got.pad);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [3:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // [31:0] ntp_seconds, [63:32] elapsed_ms
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [11:0] year, [15:12] month, [20:16] day, [23:21] weekday, [28:24] hour,
   // [34:29] minute, [40:35] second, [41] summer, [47:42] zero
   logic [47:0] rsp_tdata;

   calendar_scoreboard sb = new();

   bit          rx_random;
   int unsigned long_hold_req;

   ntp_time_to_local_calendar u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_offset(csr_wr_data);
         if (req_tvalid && req_tready) sb.note_item(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // Days from 1970-01-01 to the given civil date.
   function automatic int unsigned civil_day(int unsigned y, int unsigned m, int unsigned d);
      int unsigned yy, era, yoe, doy, doe;
      yy  = (m <= 2) ? y - 1 : y;
      era = yy / 400;
      yoe = yy - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // Result side: random stalls, and a long hold-off whenever the stimulus asks for one.
   initial begin : result_side
      int unsigned off_left;
      off_left   = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req != 0) begin
            off_left      = long_hold_req;
            long_hold_req = 0;
         end else if (off_left == 0 && rx_random && $urandom_range(0, 5) == 0) begin
            off_left = pick_gap();
         end
         if (off_left != 0) begin
            rsp_tready <= 1'b0;
            off_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [31:0] ntp, input logic [31:0] ms, input int unsigned gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, ntp};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_unix(input int unsigned unix, input logic [31:0] ms);
      send_item(unix + NTP_UNIX_DELTA - ms / 1000, ms, 0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_offset(input logic [3:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Random timestamps, weighted towards the summer-time switches and calendar boundaries.
   task automatic pick_item(input int unsigned tz, output logic [31:0] ntp,
                            output logic [31:0] ms);
      int unsigned kind, y, m, unix;
      kind = $urandom_range(0, 99);
      ms   = $urandom_range(0, 4999);
      if (kind < 30) begin
         ntp = $urandom;
         ms  = $urandom;
      end else if (kind < 70) begin
         // Around 01:00 UTC on the last days of March or October.
         y    = $urandom_range(1970, 2105);
         m    = $urandom_range(0, 1) ? MONTH_OCTOBER : MONTH_MARCH;
         unix = civil_day(y, m, $urandom_range(24, 31)) * 86400 + $urandom_range(0, 7200);
         ntp  = unix + NTP_UNIX_DELTA - ms / 1000;
      end else if (kind < 85) begin
         // A few seconds either side of local midnight at the start of a month.
         y    = $urandom_range(1970, 2105);
         m    = $urandom_range(1, 12);
         unix = civil_day(y, m, 1) * 86400 - tz * 3600 + $urandom_range(0, 20) - 10;
         ntp  = unix + NTP_UNIX_DELTA - ms / 1000;
      end else begin
         // Close to the wrap of the 32-bit sums, with large elapsed times.
         ntp = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                    : NTP_UNIX_DELTA - $urandom_range(0, 200000);
         ms  = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 100000);
      end
   endtask

   initial begin : stimulus
      logic [31:0] ntp, ms;
      logic [3:0]  tz_plan [NUM_PHASES];
      int unsigned gap;
      bit          quiet;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rx_random   = 1'b1;
      long_hold_req = 0;
      tz_plan = '{4'd15, 4'd0, 4'd14, 4'd7, 4'($urandom_range(0, 15)), 4'd1};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items with the reset offset of one hour.
      send_item(32'h0000_0000, 32'h0000_0000, 0);   // before 1970, wraps to 2036
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(NTP_UNIX_DELTA, 32'd999, 0);
      send_item(NTP_UNIX_DELTA, 32'd1000, 1);
      send_item(NTP_UNIX_DELTA - 1, 32'd0, 0);       // last Unix second, offset carries to 1970
      send_unix(32'hFFFF_FFFF - 3600, 32'd0);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 0);
      send_item(32'hAAAA_AAAA, 32'h5555_5555, 0);
      send_unix(civil_day(2024, 3, 31) * 86400 + 3599, 32'd0);   // spring switch
      send_unix(civil_day(2024, 3, 31) * 86400 + 3600, 32'd0);
      send_unix(civil_day(2024, 3, 31) * 86400 + 3600, 32'd1500);
      send_unix(civil_day(2024, 10, 27) * 86400 + 3599, 32'd0);  // autumn switch
      send_unix(civil_day(2024, 10, 27) * 86400 + 3600, 32'd0);
      send_unix(civil_day(2000, 2, 29) * 86400 + 82799, 32'd0);
      send_unix(civil_day(2100, 2, 28) * 86400 + 82800, 32'd0);  // century without leap day
      send_unix(civil_day(2099, 3, 29) * 86400 + 3600, 32'd0);
      send_unix(civil_day(2105, 10, 28) * 86400 + 3600, 32'd0);  // past the rule's valid years
      send_unix(civil_day(2024, 7, 15) * 86400 + 43200, 32'd0);
      send_unix(civil_day(2023, 12, 31) * 86400 + 84600, 32'd0);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_offset(tz_plan[p]);
         quiet     = (p == 1);
         rx_random = !quiet;
         if (p == 2) long_hold_req = 300;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pick_item(sb.tz_hours, ntp, ms);
            // During the long hold-off the sender keeps pushing so the pipeline backs up.
            if (quiet || (p == 2 && i < 80) || $urandom_range(0, 3) != 0) gap = 0;
            else gap = pick_gap();
            if (p == 3 && i == RANDOM_PER_PHASE / 2) wait_drained();
            send_item(ntp, ms, gap);
         end
         wait_drained();
      end

      repeat (40) @(negedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d calendar items still outstanding", $time, sb.pending());
         sb.errors++;
      end
      $display("Checked %0d calendar items across %0d offset settings, %0d in summer time.",
               sb.checked, NUM_PHASES + 1, sb.summer_seen);
      $display("Stimulus covered both summer-time switches, month and year edges and sum wraps.");
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("%0t: run did not finish in time", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
